@@ sv/hsvgc_pkg.sv @@
// Shared widths, constants, types and arithmetic helpers of the HSV gradient color unit.
`default_nettype none

package hsvgc_pkg;

  // Field and register widths.
  localparam int HUE_W        = 9;
  localparam int UNIT_REG_W   = 9;
  localparam int STEPS_W      = 12;
  localparam int POS_W        = 12;
  localparam int COLOR_W      = 8;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 12;
  localparam int FRAC_BITS    = 8;

  // Interpolation and division.
  localparam int PROD_W       = HUE_W + STEPS_W;
  localparam int DIVIDEND_W   = PROD_W;
  localparam int QUOT_W       = HUE_W + FRAC_BITS;
  localparam int DIV_STAGES   = 6;
  localparam int DIV_STEPS_PER_STAGE = 3;
  localparam int DIV_STEPS    = DIV_STAGES * DIV_STEPS_PER_STAGE;

  // Color conversion.
  localparam int SECTOR_Q8_INT = 15360;
  localparam int REM_W        = 14;
  localparam int MAX_SECT_IDX = ((1 << HUE_W) - 1) * (1 << FRAC_BITS) / SECTOR_Q8_INT;
  localparam int SECT_IDX_W   = $clog2(MAX_SECT_IDX + 1);
  localparam int SECTOR_COUNT = 6;
  localparam int FRAC16       = 16;
  localparam int VS_W         = 2 * QUOT_W;
  localparam int MQ_W         = REM_W + QUOT_W;
  localparam int W_W          = 30;
  localparam int P_W          = QUOT_W + W_W;
  localparam int CV_W         = QUOT_W + COLOR_W;
  localparam int CP_W         = VS_W + COLOR_W;
  localparam int YP_W         = P_W + COLOR_W;
  localparam int Y_SHIFT      = 42;
  localparam int Y_W          = 12;
  localparam int RECIP_W      = 13;
  localparam int CQ_PROD_W    = Y_W + RECIP_W;

  localparam logic [UNIT_REG_W-1:0] UNIT_REG   = 9'd256;
  localparam logic [QUOT_W-1:0]     UNIT_Q16   = 17'd65536;
  localparam logic [REM_W-1:0]      SECTOR_Q8  = 14'd15360;
  localparam logic [COLOR_W-1:0]    FULL_SCALE = 8'd255;
  localparam logic [MQ_W-1:0]       FULL_Q     = 31'd1006632960;
  localparam logic [RECIP_W-1:0]    RECIP15    = 13'd4370;

  // Pipeline stage positions.
  localparam int ST_IN      = 0;
  localparam int ST_MUL     = 1;
  localparam int ST_SUM     = 2;
  localparam int ST_DIV0    = 3;
  localparam int ST_SEL     = ST_DIV0 + DIV_STAGES;
  localparam int ST_SECT    = ST_SEL + 1;
  localparam int ST_MQ      = ST_SECT + 1;
  localparam int ST_W       = ST_MQ + 1;
  localparam int ST_P       = ST_W + 1;
  localparam int ST_Y       = ST_P + 1;
  localparam int ST_OUT     = ST_Y + 1;
  localparam int NUM_STAGES = ST_OUT + 1;

  // Reset values of the registers.
  localparam logic [HUE_W-1:0]      RST_START_HUE = 9'd0;
  localparam logic [HUE_W-1:0]      RST_END_HUE   = 9'd245;
  localparam logic [UNIT_REG_W-1:0] RST_UNIT      = 9'd256;
  localparam logic [STEPS_W-1:0]    RST_STEPS     = 12'd300;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_START_HUE        = 3'd0,
    REG_START_SATURATION = 3'd1,
    REG_START_VALUE      = 3'd2,
    REG_END_HUE          = 3'd3,
    REG_END_SATURATION   = 3'd4,
    REG_END_VALUE        = 3'd5,
    REG_GRADIENT_STEPS   = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    SEC_RED_YELLOW     = 3'd0,
    SEC_YELLOW_GREEN   = 3'd1,
    SEC_GREEN_CYAN     = 3'd2,
    SEC_CYAN_BLUE      = 3'd3,
    SEC_BLUE_MAGENTA   = 3'd4,
    SEC_MAGENTA_RED    = 3'd5
  } sector_t;

  // Working state of the restoring divider: partial remainder and a shift
  // register that starts as the low dividend bits and ends as the quotient.
  typedef struct packed {
    logic [STEPS_W-1:0]   rem;
    logic [DIV_STEPS-1:0] acc;
  } div_state_t;

  function automatic logic [UNIT_REG_W-1:0] clamp_unit(input logic [UNIT_REG_W-1:0] x);
    return (x > UNIT_REG) ? UNIT_REG : x;
  endfunction

  // The dividend is x scaled by 2^FRAC_BITS; its top bits always stay below
  // the divisor, so they seed the remainder directly.
  function automatic div_state_t div_init(input logic [DIVIDEND_W-1:0] x);
    logic [DIVIDEND_W+FRAC_BITS-1:0] d;
    div_state_t st;
    d = {x, {FRAC_BITS{1'b0}}};
    st.rem = STEPS_W'(d[DIVIDEND_W+FRAC_BITS-1:DIV_STEPS]);
    st.acc = d[DIV_STEPS-1:0];
    return st;
  endfunction

  function automatic div_state_t div_step(input div_state_t cur,
                                          input logic [STEPS_W-1:0] n);
    logic [STEPS_W:0] trial;
    div_state_t st;
    trial  = {cur.rem, cur.acc[DIV_STEPS-1]};
    st.acc = {cur.acc[DIV_STEPS-2:0], 1'b0};
    if (trial >= {1'b0, n}) begin
      trial     = trial - {1'b0, n};
      st.acc[0] = 1'b1;
    end
    st.rem = trial[STEPS_W-1:0];
    return st;
  endfunction

  // Number of whole 60 degree sectors in a hue, before wrapping.
  function automatic logic [SECT_IDX_W-1:0] sector_index(input logic [QUOT_W-1:0] h8);
    logic [SECT_IDX_W-1:0] k;
    k = '0;
    for (int i = 1; i <= MAX_SECT_IDX; i++) begin
      if (h8 >= QUOT_W'(i) * QUOT_W'(SECTOR_Q8)) k = SECT_IDX_W'(i);
    end
    return k;
  endfunction

endpackage

`default_nettype wire

@@ sv/hsvgc_div.sv @@
// Pipelined restoring divider lane: scaled dividend over the step count.
`default_nettype none

module hsvgc_div (
  input  logic                                clk,
  input  logic [hsvgc_pkg::DIV_STAGES-1:0]    load,
  input  logic [hsvgc_pkg::DIVIDEND_W-1:0]    dividend,
  input  logic [hsvgc_pkg::STEPS_W-1:0]       divisor,
  output logic [hsvgc_pkg::QUOT_W-1:0]        quotient
);
  import hsvgc_pkg::*;

  div_state_t stage_in [DIV_STAGES];
  div_state_t stage_d  [DIV_STAGES];
  div_state_t stage_q  [DIV_STAGES];

  always_comb begin
    stage_in[0] = div_init(dividend);
    for (int s = 1; s < DIV_STAGES; s++) stage_in[s] = stage_q[s-1];
  end

  // Each stage retires a few quotient bits.
  always_comb begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      stage_d[s] = stage_in[s];
      for (int i = 0; i < DIV_STEPS_PER_STAGE; i++) begin
        stage_d[s] = div_step(stage_d[s], divisor);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (load[s]) stage_q[s] <= stage_d[s];
    end
  end

  assign quotient = stage_q[DIV_STAGES-1].acc[QUOT_W-1:0];

endmodule

`default_nettype wire

@@ sv/hsv_gradient_color_unit.sv @@
// Top level of the HSV gradient color unit: interpolation, division and RGB conversion.
//
//   Channel  Dir  Handshake             Payload
//   input    in   in_valid / in_ready   position
//   output   out  out_valid / out_ready red, green, blue
//   config   in   cfg_we (no wait)      cfg_index, cfg_data
//
// One transaction per clock is accepted and one result per clock delivered
// while out_ready is high. The pipeline has 16 stages: three interpolation
// stages, six divider stages of three quotient bits each, and seven stages
// for sector split, products and the final divide by fifteen.
// Synchronous rst clears all valid bits and loads the register defaults.
// A stage advances when it is empty or its successor advances, so bubbles
// are squeezed out while the output waits; in_ready drops only when every
// stage holds a transaction and the output is not taken.
`default_nettype none

module hsv_gradient_color_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [hsvgc_pkg::POS_W-1:0]        position,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [hsvgc_pkg::COLOR_W-1:0]      red,
  output logic [hsvgc_pkg::COLOR_W-1:0]      green,
  output logic [hsvgc_pkg::COLOR_W-1:0]      blue,
  input  logic                               cfg_we,
  input  logic [hsvgc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [hsvgc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import hsvgc_pkg::*;

  // Configuration registers.
  logic [HUE_W-1:0]      start_hue;
  logic [UNIT_REG_W-1:0] start_saturation;
  logic [UNIT_REG_W-1:0] start_value;
  logic [HUE_W-1:0]      end_hue;
  logic [UNIT_REG_W-1:0] end_saturation;
  logic [UNIT_REG_W-1:0] end_value;
  logic [STEPS_W-1:0]    gradient_steps;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_hue        <= RST_START_HUE;
      start_saturation <= RST_UNIT;
      start_value      <= RST_UNIT;
      end_hue          <= RST_END_HUE;
      end_saturation   <= RST_UNIT;
      end_value        <= RST_UNIT;
      gradient_steps   <= RST_STEPS;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_START_HUE:        start_hue        <= cfg_data[HUE_W-1:0];
        REG_START_SATURATION: start_saturation <= cfg_data[UNIT_REG_W-1:0];
        REG_START_VALUE:      start_value      <= cfg_data[UNIT_REG_W-1:0];
        REG_END_HUE:          end_hue          <= cfg_data[HUE_W-1:0];
        REG_END_SATURATION:   end_saturation   <= cfg_data[UNIT_REG_W-1:0];
        REG_END_VALUE:        end_value        <= cfg_data[UNIT_REG_W-1:0];
        REG_GRADIENT_STEPS:   gradient_steps   <= cfg_data[STEPS_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturation and value above 1.0 are clamped before interpolation.
  logic [UNIT_REG_W-1:0] sat_a, sat_b, val_a, val_b;
  assign sat_a = clamp_unit(start_saturation);
  assign sat_b = clamp_unit(end_saturation);
  assign val_a = clamp_unit(start_value);
  assign val_b = clamp_unit(end_value);

  // Pipeline flow control. Each stage carries a valid bit; a stage loads
  // when it is empty or when the stage after it loads.
  logic [NUM_STAGES-1:0] stage_valid;
  logic [NUM_STAGES-1:0] adv;

  always_comb begin
    adv[NUM_STAGES-1] = !stage_valid[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !stage_valid[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (adv[0]) stage_valid[0] <= in_valid;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv[k]) stage_valid[k] <= stage_valid[k-1];
      end
    end
  end

  assign in_ready  = adv[ST_IN];
  assign out_valid = stage_valid[ST_OUT];

  // Stage 0: saturate the position at the step count.
  logic [POS_W-1:0]   p_sat;
  logic [STEPS_W-1:0] p_r;
  logic [STEPS_W-1:0] np_r;

  assign p_sat = (position > gradient_steps) ? gradient_steps : position;

  always_ff @(posedge clk) begin
    if (adv[ST_IN]) begin
      p_r  <= p_sat;
      np_r <= gradient_steps - p_sat;
    end
  end

  // Stage 1: endpoint weights.
  logic [PROD_W-1:0] mul_hue_a, mul_hue_b, mul_sat_a, mul_sat_b, mul_val_a, mul_val_b;

  always_ff @(posedge clk) begin
    if (adv[ST_MUL]) begin
      mul_hue_a <= PROD_W'(start_hue) * PROD_W'(np_r);
      mul_hue_b <= PROD_W'(end_hue)   * PROD_W'(p_r);
      mul_sat_a <= PROD_W'(sat_a)     * PROD_W'(np_r);
      mul_sat_b <= PROD_W'(sat_b)     * PROD_W'(p_r);
      mul_val_a <= PROD_W'(val_a)     * PROD_W'(np_r);
      mul_val_b <= PROD_W'(val_b)     * PROD_W'(p_r);
    end
  end

  // Stage 2: weighted sums. They never exceed the largest endpoint times
  // the step count, so they fit the product width.
  logic [DIVIDEND_W-1:0] sum_hue, sum_sat, sum_val;

  always_ff @(posedge clk) begin
    if (adv[ST_SUM]) begin
      sum_hue <= mul_hue_a + mul_hue_b;
      sum_sat <= mul_sat_a + mul_sat_b;
      sum_val <= mul_val_a + mul_val_b;
    end
  end

  // Divider stages: three lanes share the step count as divisor.
  logic [QUOT_W-1:0] q_hue, q_sat, q_val;

  hsvgc_div u_div_hue (
    .clk      (clk),
    .load     (adv[ST_DIV0 +: DIV_STAGES]),
    .dividend (sum_hue),
    .divisor  (gradient_steps),
    .quotient (q_hue)
  );

  hsvgc_div u_div_sat (
    .clk      (clk),
    .load     (adv[ST_DIV0 +: DIV_STAGES]),
    .dividend (sum_sat),
    .divisor  (gradient_steps),
    .quotient (q_sat)
  );

  hsvgc_div u_div_val (
    .clk      (clk),
    .load     (adv[ST_DIV0 +: DIV_STAGES]),
    .dividend (sum_val),
    .divisor  (gradient_steps),
    .quotient (q_val)
  );

  // Stage 9: with a zero step count the start endpoint is used as is.
  logic [QUOT_W-1:0] h8_r, s16_r, v16_r;
  logic              steps_zero;

  assign steps_zero = (gradient_steps == '0);

  always_ff @(posedge clk) begin
    if (adv[ST_SEL]) begin
      h8_r  <= steps_zero ? {start_hue, {FRAC_BITS{1'b0}}} : q_hue;
      s16_r <= steps_zero ? {sat_a, {FRAC_BITS{1'b0}}}     : q_sat;
      v16_r <= steps_zero ? {val_a, {FRAC_BITS{1'b0}}}     : q_val;
    end
  end

  // Stage 10: split the hue into a sector and the offset inside it, and
  // form v*(1-s) for the P channel.
  logic [SECT_IDX_W-1:0] sect_idx;
  logic [SECT_IDX_W-1:0] sect_wrap;
  logic [QUOT_W-1:0]     rem_full;
  sector_t               sect_b;
  logic [REM_W-1:0]      rem_b;
  logic [QUOT_W-1:0]     s16_b, v16_b;
  logic [VS_W-1:0]       vs_b;

  assign sect_idx  = sector_index(h8_r);
  assign sect_wrap = (sect_idx >= SECT_IDX_W'(SECTOR_COUNT))
                   ? sect_idx - SECT_IDX_W'(SECTOR_COUNT) : sect_idx;
  assign rem_full  = h8_r - QUOT_W'(sect_idx) * QUOT_W'(SECTOR_Q8);

  always_ff @(posedge clk) begin
    if (adv[ST_SECT]) begin
      sect_b <= sector_t'(sect_wrap[2:0]);
      rem_b  <= rem_full[REM_W-1:0];
      s16_b  <= s16_r;
      v16_b  <= v16_r;
      vs_b   <= VS_W'(v16_r) * VS_W'(UNIT_Q16 - s16_r);
    end
  end

  // Stage 11: saturation weighted by the sector offset; V and P finish here.
  logic [CV_W-1:0]    cv_prod;
  logic [CP_W-1:0]    cp_prod;
  logic [MQ_W-1:0]    mq_c, mt_c;
  logic [COLOR_W-1:0] cv_c, cp_c;
  logic [QUOT_W-1:0]  v16_c;
  sector_t            sect_c;

  assign cv_prod = CV_W'(v16_b) * CV_W'(FULL_SCALE);
  assign cp_prod = {vs_b, {COLOR_W{1'b0}}} - CP_W'(vs_b);

  always_ff @(posedge clk) begin
    if (adv[ST_MQ]) begin
      mq_c   <= MQ_W'(rem_b) * MQ_W'(s16_b);
      mt_c   <= MQ_W'(SECTOR_Q8 - rem_b) * MQ_W'(s16_b);
      cv_c   <= cv_prod[FRAC16+COLOR_W-1:FRAC16];
      cp_c   <= cp_prod[2*FRAC16+COLOR_W-1:2*FRAC16];
      v16_c  <= v16_b;
      sect_c <= sect_b;
    end
  end

  // Stage 12: one minus the weighted saturation, in units of 2^16 * 15360.
  logic [MQ_W-1:0]    wq_full, wt_full;
  logic [W_W-1:0]     wq_d, wt_d;
  logic [COLOR_W-1:0] cv_d, cp_d;
  logic [QUOT_W-1:0]  v16_d;
  sector_t            sect_d;

  assign wq_full = FULL_Q - mq_c;
  assign wt_full = FULL_Q - mt_c;

  always_ff @(posedge clk) begin
    if (adv[ST_W]) begin
      wq_d   <= wq_full[W_W-1:0];
      wt_d   <= wt_full[W_W-1:0];
      cv_d   <= cv_c;
      cp_d   <= cp_c;
      v16_d  <= v16_c;
      sect_d <= sect_c;
    end
  end

  // Stage 13: scale by value.
  logic [P_W-1:0]     pq_e, pt_e;
  logic [COLOR_W-1:0] cv_e, cp_e;
  sector_t            sect_e;

  always_ff @(posedge clk) begin
    if (adv[ST_P]) begin
      pq_e   <= P_W'(v16_d) * P_W'(wq_d);
      pt_e   <= P_W'(v16_d) * P_W'(wt_d);
      cv_e   <= cv_d;
      cp_e   <= cp_d;
      sect_e <= sect_d;
    end
  end

  // Stage 14: times 255 and drop the power-of-two part of the denominator;
  // what is left still has to be divided by fifteen.
  logic [YP_W-1:0]    yq_prod, yt_prod;
  logic [Y_W-1:0]     yq_f, yt_f;
  logic [COLOR_W-1:0] cv_f, cp_f;
  sector_t            sect_f;

  assign yq_prod = {pq_e, {COLOR_W{1'b0}}} - YP_W'(pq_e);
  assign yt_prod = {pt_e, {COLOR_W{1'b0}}} - YP_W'(pt_e);

  always_ff @(posedge clk) begin
    if (adv[ST_Y]) begin
      yq_f   <= yq_prod[Y_SHIFT+Y_W-1:Y_SHIFT];
      yt_f   <= yt_prod[Y_SHIFT+Y_W-1:Y_SHIFT];
      cv_f   <= cv_e;
      cp_f   <= cp_e;
      sect_f <= sect_e;
    end
  end

  // Stage 15: divide by fifteen through a reciprocal that is exact over the
  // whole range of the operand, then route channels by sector.
  logic [CQ_PROD_W-1:0] cq_prod, ct_prod;
  logic [COLOR_W-1:0]   cq, ct;
  logic [COLOR_W-1:0]   red_next, green_next, blue_next;

  assign cq_prod = CQ_PROD_W'(yq_f) * CQ_PROD_W'(RECIP15);
  assign ct_prod = CQ_PROD_W'(yt_f) * CQ_PROD_W'(RECIP15);
  assign cq      = cq_prod[FRAC16+COLOR_W-1:FRAC16];
  assign ct      = ct_prod[FRAC16+COLOR_W-1:FRAC16];

  always_comb begin
    case (sect_f)
      SEC_RED_YELLOW:   begin red_next = cv_f; green_next = ct;   blue_next = cp_f; end
      SEC_YELLOW_GREEN: begin red_next = cq;   green_next = cv_f; blue_next = cp_f; end
      SEC_GREEN_CYAN:   begin red_next = cp_f; green_next = cv_f; blue_next = ct;   end
      SEC_CYAN_BLUE:    begin red_next = cp_f; green_next = cq;   blue_next = cv_f; end
      SEC_BLUE_MAGENTA: begin red_next = ct;   green_next = cp_f; blue_next = cv_f; end
      default:          begin red_next = cv_f; green_next = cp_f; blue_next = cq;   end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[ST_OUT]) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

  // The input side only backs up when the whole pipeline is occupied.
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> &stage_valid)
    else $error("input stalled while a pipeline stage was empty");

  // Transactions in flight change only by what enters and what leaves.
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ($countones(stage_valid) ==
      $countones($past(stage_valid)) + ($past(in_valid && in_ready) ? 1 : 0)
      - ($past(out_valid && out_ready) ? 1 : 0)))
    else $error("pipeline occupancy does not match accepted transactions");

  // A new result comes only from the stage just before the output.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $rose(out_valid) |-> $past(stage_valid[ST_OUT-1]))
    else $error("result appeared without a transaction in the stage before it");

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench of the HSV gradient color unit with a built-in color predictor.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hsvgc_pkg::*;

  // The block is a 16-stage pipeline; the drain wait adds a little margin on top.
  localparam int PIPE_LATENCY = NUM_STAGES + 4;
  localparam int ITEMS_PER_SETTING = 90;
  localparam int SETTINGS_PER_PHASE = 6;
  localparam int LONG_STALL_CYCLES = 400;
  localparam int STALL_ITEMS = 80;
  localparam int MAX_REPORTED = 10;
  // Index 7 lies outside the register map, so a write there must be ignored.
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } color_t;

  // Ports of the block. Every input starts at a known value.
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [POS_W-1:0]       position = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [COLOR_W-1:0]     red;
  logic [COLOR_W-1:0]     green;
  logic [COLOR_W-1:0]     blue;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Shadow copy of the gradient registers, loaded with the reset defaults.
  logic [HUE_W-1:0]      hue_from  = RST_START_HUE;
  logic [UNIT_REG_W-1:0] sat_from  = RST_UNIT;
  logic [UNIT_REG_W-1:0] val_from  = RST_UNIT;
  logic [HUE_W-1:0]      hue_to    = RST_END_HUE;
  logic [UNIT_REG_W-1:0] sat_to    = RST_UNIT;
  logic [UNIT_REG_W-1:0] val_to    = RST_UNIT;
  logic [STEPS_W-1:0]    step_count = RST_STEPS;

  // Colors predicted for accepted positions, oldest first.
  color_t expected_colors[$];
  int     mismatch_count = 0;

  // Idle rates of both sides in percent, and a request for one long output stall.
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     stall_request = 0;

  hsv_gradient_color_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .position  (position),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // A hard ceiling on the run time: far beyond the slowest correct run.
  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Linear blend of two endpoints with 8 fraction bits. With no steps at all the
  // start endpoint holds for every position.
  function automatic longint unsigned blend_q8(input longint unsigned a,
                                               input longint unsigned b,
                                               input longint unsigned p,
                                               input longint unsigned n);
    if (n == 0) return a << 8;
    return ((a * (n - p) + b * p) << 8) / n;
  endfunction

  // Computes the color that the block must return for one position under the
  // current shadow registers. All channels are exact rationals rounded down.
  function automatic color_t predict_color(input logic [POS_W-1:0] pos);
    longint unsigned n, p, h8, s16, v16, sector, rem, unit, span, den, full;
    longint unsigned cv, cp, cq, ct, s_a, s_b, v_a, v_b;
    color_t c;
    unit = 64'd65536;
    span = longint'(SECTOR_Q8);
    n = step_count;
    p = pos;
    // A position past the end of the bar is pinned to the end endpoint.
    if (p > n) p = n;
    // Saturation and value registers above 1.0 count as exactly 1.0.
    s_a = (sat_from > UNIT_REG) ? UNIT_REG : sat_from;
    s_b = (sat_to > UNIT_REG) ? UNIT_REG : sat_to;
    v_a = (val_from > UNIT_REG) ? UNIT_REG : val_from;
    v_b = (val_to > UNIT_REG) ? UNIT_REG : val_to;
    h8 = blend_q8(hue_from, hue_to, p, n);
    s16 = blend_q8(s_a, s_b, p, n);
    v16 = blend_q8(v_a, v_b, p, n);
    // Hues of 360 degrees and beyond wrap around the six sectors.
    sector = (h8 / span) % SECTOR_COUNT;
    rem = h8 % span;
    den = unit * unit * span;
    full = unit * span;
    cv = (longint'(FULL_SCALE) * v16) >> 16;
    cp = (longint'(FULL_SCALE) * v16 * (unit - s16)) >> 32;
    cq = (longint'(FULL_SCALE) * v16 * (full - rem * s16)) / den;
    ct = (longint'(FULL_SCALE) * v16 * (full - (span - rem) * s16)) / den;
    case (sector_t'(sector[2:0]))
      SEC_RED_YELLOW: begin
        c.red = cv[7:0]; c.green = ct[7:0]; c.blue = cp[7:0];
      end
      SEC_YELLOW_GREEN: begin
        c.red = cq[7:0]; c.green = cv[7:0]; c.blue = cp[7:0];
      end
      SEC_GREEN_CYAN: begin
        c.red = cp[7:0]; c.green = cv[7:0]; c.blue = ct[7:0];
      end
      SEC_CYAN_BLUE: begin
        c.red = cp[7:0]; c.green = cq[7:0]; c.blue = cv[7:0];
      end
      SEC_BLUE_MAGENTA: begin
        c.red = ct[7:0]; c.green = cp[7:0]; c.blue = cv[7:0];
      end
      default: begin
        c.red = cv[7:0]; c.green = cp[7:0]; c.blue = cq[7:0];
      end
    endcase
    return c;
  endfunction

  // Receiver. Normally out_ready follows the idle rate; a stall request holds it
  // low for a long stretch so that the pipeline fills and in_ready drops.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_request != 0) begin
        stall_left = stall_request;
        stall_request = 0;
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Result checker: each output transaction is compared with the oldest
  // prediction, channel by channel.
  always @(posedge clk) begin
    color_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_colors.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTED)
          $display("%0t: unexpected color r=%0d g=%0d b=%0d", $realtime, red, green, blue);
      end else begin
        want = expected_colors.pop_front();
        if (red !== want.red || green !== want.green || blue !== want.blue) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTED)
            $display("%0t: color mismatch, expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     $realtime, want.red, want.green, want.blue, red, green, blue);
        end
      end
    end
  end

  // Offers one position and waits for the input transaction. in_valid stays
  // high on return so that back-to-back positions need no extra edge.
  task automatic send_position(input logic [POS_W-1:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    position <= pos;
    do @(posedge clk); while (!in_ready);
    expected_colors.push_back(predict_color(pos));
  endtask

  // Stops offering and waits until every predicted color has come out, then
  // lets the pipeline run empty.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  // One register write; the shadow copy follows with the same masking as the
  // hardware. cfg_we is left high so that writes can follow back to back.
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_START_HUE:        hue_from = data[8:0];
      REG_START_SATURATION: sat_from = data[8:0];
      REG_START_VALUE:      val_from = data[8:0];
      REG_END_HUE:          hue_to = data[8:0];
      REG_END_SATURATION:   sat_to = data[8:0];
      REG_END_VALUE:        val_to = data[8:0];
      REG_GRADIENT_STEPS:   step_count = data;
      default: ;
    endcase
  endtask

  task automatic load_gradient(input logic [CFG_DATA_W-1:0] h0, input logic [CFG_DATA_W-1:0] s0,
                               input logic [CFG_DATA_W-1:0] v0, input logic [CFG_DATA_W-1:0] h1,
                               input logic [CFG_DATA_W-1:0] s1, input logic [CFG_DATA_W-1:0] v1,
                               input logic [CFG_DATA_W-1:0] n);
    write_register(REG_START_HUE, h0);
    write_register(REG_START_SATURATION, s0);
    write_register(REG_START_VALUE, v0);
    write_register(REG_END_HUE, h1);
    write_register(REG_END_SATURATION, s1);
    write_register(REG_END_VALUE, v1);
    write_register(REG_GRADIENT_STEPS, n);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Saturation or value setting: mostly in range, with the extremes and full
  // 12-bit data words mixed in.
  function automatic logic [CFG_DATA_W-1:0] pick_unit_setting();
    case ($urandom_range(5))
      0: return '0;
      1: return CFG_DATA_W'(UNIT_REG);
      2: return CFG_DATA_W'($urandom_range(4095));
      default: return CFG_DATA_W'($urandom_range(256));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_hue_setting();
    case ($urandom_range(7))
      0: return '0;
      1: return 12'd359;
      2: return CFG_DATA_W'($urandom_range(4095));
      default: return CFG_DATA_W'($urandom_range(359));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_step_setting();
    case ($urandom_range(9))
      0: return 12'd4095;
      1: return 12'd1;
      2: return 12'd0;
      3: return CFG_DATA_W'($urandom_range(1, 4095));
      default: return CFG_DATA_W'($urandom_range(1, 600));
    endcase
  endfunction

  // Mostly positions along the bar and just past its end, some anywhere.
  function automatic logic [POS_W-1:0] pick_position();
    int top;
    top = int'(step_count) + 2;
    if (top > 4095) top = 4095;
    if ($urandom_range(7) == 0) return POS_W'($urandom_range(4095));
    return POS_W'($urandom_range(top));
  endfunction

  // Reset defaults: a red to blue bar of 300 steps, probed at both ends,
  // the middle and well past the end.
  task automatic test_reset_defaults();
    send_position(12'd0);
    send_position(12'd150);
    send_position(12'd300);
    send_position(12'd301);
    send_position(12'd4095);
    wait_drained();
  endtask

  // One full turn of the hue wheel in six steps, so every sector is visited.
  task automatic test_hue_sectors();
    load_gradient(12'd0, 12'd256, 12'd256, 12'd359, 12'd256, 12'd256, 12'd6);
    for (int k = 0; k <= 6; k++) send_position(POS_W'(k));
    wait_drained();
  endtask

  // Hues of 360 degrees and beyond wrap; saturation and value above 1.0 are
  // clamped. The largest step count is used with the last positions.
  task automatic test_wrap_and_clamp();
    load_gradient(12'd511, 12'd511, 12'd511, 12'd360, 12'd300, 12'd257, 12'd4095);
    send_position(12'd0);
    send_position(12'd4094);
    send_position(12'd4095);
    wait_drained();
  endtask

  // With a step count of zero the start endpoint is returned for any position.
  task automatic test_zero_steps();
    load_gradient(12'd100, 12'd128, 12'd200, 12'd300, 12'd0, 12'd0, 12'd0);
    send_position(12'd0);
    send_position(12'd4095);
    wait_drained();
  endtask

  // Gray and black: zero saturation and zero value at the start, one step only.
  task automatic test_gray_and_black();
    load_gradient(12'd200, 12'd0, 12'd0, 12'd40, 12'd256, 12'd256, 12'd1);
    send_position(12'd0);
    send_position(12'd1);
    send_position(12'd2);
    wait_drained();
  endtask

  // A write outside the register map must leave every register alone, and the
  // upper data bits of a 9-bit register are dropped.
  task automatic test_unmapped_write();
    write_register(REG_UNUSED, 12'hFFF);
    write_register(REG_START_HUE, 12'hE2D);
    cfg_we <= 1'b0;
    @(posedge clk);
    send_position(12'd0);
    send_position(12'd1);
    wait_drained();
  endtask

  // Random gradients under one idle profile, each followed by a full drain so
  // the next settings are written while the block is empty.
  task automatic test_random_gradients(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (SETTINGS_PER_PHASE) begin
      load_gradient(pick_hue_setting(), pick_unit_setting(), pick_unit_setting(),
                    pick_hue_setting(), pick_unit_setting(), pick_unit_setting(),
                    pick_step_setting());
      repeat (ITEMS_PER_SETTING) send_position(pick_position());
      wait_drained();
    end
  endtask

  // The receiver holds off for a long stretch while positions keep coming, so
  // the pipeline fills up and has to stall its input.
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_gradient(pick_hue_setting(), pick_unit_setting(), pick_unit_setting(),
                  pick_hue_setting(), pick_unit_setting(), pick_unit_setting(), 12'd200);
    stall_request = LONG_STALL_CYCLES;
    repeat (STALL_ITEMS) send_position(pick_position());
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_hue_sectors();
    test_wrap_and_clamp();
    test_zero_steps();
    test_gray_and_black();
    test_unmapped_write();
    test_output_stall();
    test_random_gradients(10, 73);
    test_random_gradients(73, 10);
    test_random_gradients(0, 0);

    // wait_drained has already let the pipeline run empty; any stray output
    // in that window is caught by the checker.
    wait_drained();
    if (mismatch_count == 0 && expected_colors.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
sv/hsvgc_pkg.sv
sv/hsvgc_div.sv
sv/hsv_gradient_color_unit.sv
sim/tb_top.sv
